FILE: design/imf_pkg.sv
package imf_pkg;

  localparam int unsigned FrameLen   = 28;
  localparam int unsigned CrcSpan    = 24;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned IdxW       = 5;
  localparam int unsigned PaddrW     = 3;

  localparam logic [IdxW-1:0] LastIdx     = IdxW'(FrameLen - 1);
  localparam logic [IdxW-1:0] CrcFirstIdx = IdxW'(CrcSpan);
  localparam logic [31:0]     CrcPoly     = 32'h04C1_1DB7;
  localparam logic [31:0]     CrcSeedRst  = 32'hFFFF_FFFF;
  localparam logic [7:0]      HeaderByte  = 8'h91;

  // register index carried in paddr[2]
  localparam logic RegCrcSeed = 1'b0;

  typedef struct packed {
    logic signed [23:0] roll_rate;
    logic signed [23:0] pitch_rate;
    logic signed [23:0] yaw_rate;
    logic signed [23:0] accel_x;
    logic signed [23:0] accel_y;
    logic signed [23:0] accel_z;
    logic        [7:0]  time_count;
  } sample_t;

  typedef struct packed {
    logic    valid;
    sample_t data;
  } head_t;

  function automatic logic [7:0] flip8(logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = b[i];
    end
    return r;
  endfunction

  function automatic logic [31:0] flip32(logic [31:0] x);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) begin
      r[31-i] = x[i];
    end
    return r;
  endfunction

  // one datagram byte through the MSB-first register, input bits reversed
  function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {flip8(b), 24'h0};
    for (int k = 0; k < 8; k++) begin
      r = r[31] ? ((r << 1) ^ CrcPoly) : (r << 1);
    end
    return r;
  endfunction

  function automatic logic [7:0] frame_byte(sample_t s, logic [IdxW-1:0] idx,
                                            logic [31:0] crc_out);
    logic [7:0] b;
    unique case (idx)
      5'd0:    b = HeaderByte;
      5'd1:    b = s.roll_rate[23:16];
      5'd2:    b = s.roll_rate[15:8];
      5'd3:    b = s.roll_rate[7:0];
      5'd4:    b = s.pitch_rate[23:16];
      5'd5:    b = s.pitch_rate[15:8];
      5'd6:    b = s.pitch_rate[7:0];
      5'd7:    b = s.yaw_rate[23:16];
      5'd8:    b = s.yaw_rate[15:8];
      5'd9:    b = s.yaw_rate[7:0];
      5'd11:   b = s.accel_x[23:16];
      5'd12:   b = s.accel_x[15:8];
      5'd13:   b = s.accel_x[7:0];
      5'd14:   b = s.accel_y[23:16];
      5'd15:   b = s.accel_y[15:8];
      5'd16:   b = s.accel_y[7:0];
      5'd17:   b = s.accel_z[23:16];
      5'd18:   b = s.accel_z[15:8];
      5'd19:   b = s.accel_z[7:0];
      5'd21:   b = s.time_count;
      5'd24:   b = crc_out[31:24];
      5'd25:   b = crc_out[23:16];
      5'd26:   b = crc_out[15:8];
      5'd27:   b = crc_out[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: design/imf_if.sv
interface imf_sample_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] roll_rate;
  logic signed [23:0] pitch_rate;
  logic signed [23:0] yaw_rate;
  logic signed [23:0] accel_x;
  logic signed [23:0] accel_y;
  logic signed [23:0] accel_z;
  logic        [7:0]  time_count;

  modport source (
    output valid, roll_rate, pitch_rate, yaw_rate, accel_x, accel_y, accel_z, time_count,
    input  ready
  );
  modport sink (
    input  valid, roll_rate, pitch_rate, yaw_rate, accel_x, accel_y, accel_z, time_count,
    output ready
  );
endinterface

interface imf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, frame_byte, last_byte, input ready);
  modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

FILE: design/imf_front.sv
module imf_front #(
  parameter int unsigned QueueDepth = imf_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  imf_sample_if.sink       sample_i,
  input  logic             pop_i,
  output imf_pkg::head_t   head_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QueueDepth);

  imf_pkg::sample_t mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;
  imf_pkg::sample_t wr_data;

  assign sample_i.ready = (cnt_q != CntFull);
  assign push = sample_i.valid && sample_i.ready;
  assign pop  = pop_i && (cnt_q != '0);

  always_comb begin
    wr_data.roll_rate  = sample_i.roll_rate;
    wr_data.pitch_rate = sample_i.pitch_rate;
    wr_data.yaw_rate   = sample_i.yaw_rate;
    wr_data.accel_x    = sample_i.accel_x;
    wr_data.accel_y    = sample_i.accel_y;
    wr_data.accel_z    = sample_i.accel_z;
    wr_data.time_count = sample_i.time_count;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.data  = mem_q[rd_ptr_q];

endmodule

FILE: design/imf_back.sv
module imf_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [31:0]    crc_seed_i,
  input  imf_pkg::head_t head_i,
  output logic           pop_o,
  imf_byte_if.source     frame_o
);

  logic [imf_pkg::IdxW-1:0] idx_q, idx_d;
  logic [31:0]              crc_q, crc_d, crc_base, crc_out;
  logic [7:0]               byte_q, byte_d;
  logic                     oval_q, olast_q, adv, at_last;

  assign at_last  = (idx_q == imf_pkg::LastIdx);
  assign adv      = head_i.valid && (!oval_q || frame_o.ready);
  assign pop_o    = adv && at_last;
  assign crc_base = (idx_q == '0) ? crc_seed_i : crc_q;
  assign crc_out  = imf_pkg::flip32(~crc_q);
  assign byte_d   = imf_pkg::frame_byte(head_i.data, idx_q, crc_out);

  always_comb begin
    idx_d = idx_q;
    crc_d = crc_q;
    if (adv) begin
      idx_d = at_last ? '0 : idx_q + 1'b1;
      if (idx_q < imf_pkg::CrcFirstIdx) begin
        crc_d = imf_pkg::crc_step(crc_base, byte_d);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      oval_q  <= 1'b0;
      olast_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (adv) begin
        oval_q  <= 1'b1;
        olast_q <= at_last;
      end else if (frame_o.ready) begin
        oval_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
    if (adv) begin
      byte_q <= byte_d;
    end
  end

  assign frame_o.valid      = oval_q;
  assign frame_o.frame_byte = byte_q;
  assign frame_o.last_byte  = olast_q;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= imf_pkg::LastIdx)
    else $error("byte index past end of datagram");

  a_pop_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (oval_q && olast_q && idx_q == '0))
    else $error("sample released without last byte");

  a_last_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !at_last) |=> !olast_q)
    else $error("last flag on inner byte");

endmodule

FILE: design/imf_datagram_framer_crc32_core.sv
// IMU datagram framer. Each accepted sample becomes a 28-byte datagram on the
// byte output, one byte per transaction, header 0x91 first and the big-endian
// CRC-32 (reflected, final inversion, seeded from crc_seed) last, flagged by
// last_byte. The output runs at one byte per cycle while the byte output is
// ready; the serializer folds each of bytes 0-23 into the CRC as it goes out
// and sets the sustained sample rate. Samples wait in a QueueDepth-entry
// queue, so the input keeps accepting while a datagram is still streaming,
// as long as the queue has room; when idle, an accepted sample is written
// into the queue, then its first byte is registered into the output stage.
// crc_seed sits at address 0 and resets to 0xFFFFFFFF (standard CRC-32).
module imu_datagram_framer_crc32_core #(
  parameter int unsigned QueueDepth = imf_pkg::QueueDepth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  imf_sample_if.sink                sample_i,
  imf_byte_if.source                frame_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [imf_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  logic [31:0]    crc_seed_q;
  imf_pkg::head_t head;
  logic           pop;
  logic           reg_wr;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && (paddr[2] == imf_pkg::RegCrcSeed);
  assign prdata = (paddr[2] == imf_pkg::RegCrcSeed) ? crc_seed_q : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_seed_q <= imf_pkg::CrcSeedRst;
    end else if (reg_wr) begin
      crc_seed_q <= pwdata;
    end
  end

  imf_front #(
    .QueueDepth (QueueDepth)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_i),
    .pop_i    (pop),
    .head_o   (head)
  );

  imf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .crc_seed_i (crc_seed_q),
    .head_i     (head),
    .pop_o      (pop),
    .frame_o    (frame_o)
  );

endmodule
